// File: hdl/sha_pkg.sv
// Package for the SHA-256 stream hasher: round constants, initial hash values,
// SHA-256 bit functions and the block descriptor type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;

    // Block descriptor handed from the front end to the compression engine.
    typedef struct packed {
        logic [511:0] block;   // word 0 in the top bits
        logic         last;    // final block of a message: emit digest after it
    } t_blk;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [255:0] init_hash();
        return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction
    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction
    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction
    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage
`default_nettype wire

// File: hdl/sha_front.sv
// Front end of the SHA-256 hasher: gathers bytes into 64-byte blocks,
// appends padding and length, and emits block descriptors. Uses sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_front import sha_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end,
    output logic             o_blk_valid,
    input  wire logic        i_blk_ready,
    output t_blk             o_blk
);

    typedef enum logic [1:0] {S_GATHER, S_PAD2} t_state;

    t_state       r_state;
    logic [511:0] r_buf;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic         r_ovalid;
    t_blk         r_oblk;

    logic [511:0] w_buf;
    logic [6:0]   w_fill;
    logic [63:0]  w_bits;
    logic [511:0] w_pad;
    logic         w_take;
    logic         w_slot;

    // Output slot is free when empty or being drained.
    assign w_slot  = !r_ovalid || i_blk_ready;
    assign o_ready = (r_state == S_GATHER) && w_slot;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        w_buf  = r_buf;
        w_fill = {1'b0, r_fill};
        w_bits = r_bits;
        if (i_has_byte) begin
            w_buf[511 - 8*r_fill -: 8] = i_byte;
            w_fill = w_fill + 7'd1;
            w_bits = r_bits + 64'd8;
        end
        // Padding form of the current partial block: 0x80 then zeros.
        w_pad = w_buf;
        for (int i = 0; i < 64; i++) begin
            if (7'(i) == w_fill) w_pad[511 - 8*i -: 8] = 8'h80;
            else if (7'(i) > w_fill) w_pad[511 - 8*i -: 8] = 8'h00;
        end
    end

    assign o_blk_valid = r_ovalid;
    assign o_blk       = r_oblk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_GATHER;
            r_fill   <= '0;
            r_bits   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_blk_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_GATHER: begin
                    if (w_take) begin
                        r_buf  <= w_buf;
                        r_fill <= w_fill[5:0];
                        r_bits <= w_bits;
                        if (w_fill[6] && !i_end) begin
                            r_ovalid <= 1'b1;
                            r_oblk   <= '{block: w_buf, last: 1'b0};
                        end else if (w_fill[6]) begin
                            // Full block then a separate padding block.
                            r_ovalid <= 1'b1;
                            r_oblk   <= '{block: w_buf, last: 1'b0};
                            r_buf    <= {8'h80, 504'd0};
                            r_state  <= S_PAD2;
                        end else if (i_end && w_fill >= 7'd56) begin
                            r_ovalid <= 1'b1;
                            r_oblk   <= '{block: w_pad, last: 1'b0};
                            r_buf    <= '0;
                            r_state  <= S_PAD2;
                        end else if (i_end) begin
                            r_ovalid <= 1'b1;
                            r_oblk   <= '{block: {w_pad[511:64], w_bits}, last: 1'b1};
                            r_fill   <= '0;
                            r_bits   <= '0;
                        end
                    end
                end
                S_PAD2: begin
                    if (w_slot) begin
                        r_ovalid <= 1'b1;
                        r_oblk   <= '{block: {r_buf[511:64], r_bits}, last: 1'b1};
                        r_fill   <= '0;
                        r_bits   <= '0;
                        r_state  <= S_GATHER;
                    end
                end
                default: r_state <= S_GATHER;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/sha_fifo.sv
// Two-entry queue of block descriptors between the front end and the
// compression engine. Uses sha_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none
module sha_fifo import sha_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_blk      i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_blk      o_data
);

    t_blk       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

// File: hdl/sha_core.sv
// Compression engine of the SHA-256 hasher: one round per cycle over a
// rolling 16-word schedule, then digest words out after a final block. Uses sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_core import sha_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_blk_valid,
    output logic             o_blk_ready,
    input  t_blk             i_blk,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_word,
    output logic [2:0]       o_index,
    output logic             o_last
);

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FOLD, S_EMIT} t_state;

    t_state        r_state;
    logic [255:0]  r_chain;
    logic [31:0]   r_v [8];
    logic [511:0]  r_w;       // w[t] in the top word
    logic [5:0]    r_round;
    logic          r_last;
    logic [2:0]    r_idx;

    logic [31:0] w_wt, w_next, w_t1, w_t2;
    logic [31:0] w_a, w_e;

    assign w_a  = r_v[0];
    assign w_e  = r_v[4];
    assign w_wt = r_w[511:480];
    // Schedule word w[t+16] from w[t], w[t+1], w[t+9], w[t+14].
    assign w_next = w_wt + ssig0(r_w[479:448]) + r_w[223:192] + ssig1(r_w[63:32]);
    assign w_t1 = r_v[7] + bsig1(w_e) + ((w_e & r_v[5]) ^ (~w_e & r_v[6]))
                + round_k(r_round) + w_wt;
    assign w_t2 = bsig0(w_a) + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign o_blk_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_EMIT);
    assign o_word      = r_chain[255 - 32*r_idx -: 32];
    assign o_index     = r_idx;
    assign o_last      = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chain <= init_hash();
            r_round <= '0;
            r_idx   <= '0;
            for (int i = 0; i < 8; i++) r_v[i] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_blk_valid) begin
                        r_w     <= i_blk.block;
                        r_last  <= i_blk.last;
                        r_round <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_chain[255 - 32*i -: 32];
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_w <= {r_w[479:0], w_next};
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= w_e;
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= w_a;
                    r_v[0] <= w_t1 + w_t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(ROUNDS - 1)) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++)
                        r_chain[255 - 32*i -: 32] <= r_chain[255 - 32*i -: 32] + r_v[i];
                    r_idx   <= '0;
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_chain <= init_hash();
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: front end, block queue and
// compression engine. Depends on sha_pkg, sha_front, sha_fifo and sha_core.
`timescale 1ns / 1ps
`default_nettype none
// The hasher takes one message byte per input beat and returns the SHA-256
// digest as eight output beats, word 0 first, after the beat marked by tlast.
// A byte beat is taken every cycle while the front end gathers a block and
// its output slot is free; a full 64-byte block goes into a two-entry queue
// and the compression engine runs it as a load, 64 rounds at one per cycle
// and a fold. Bytes keep flowing while a block compresses, so a long message
// sustains about one byte per cycle with short stalls when the queue fills.
// The final beat adds one or two padded blocks; the digest comes out after the
// last block's fold, one word per beat. The final beat may carry no byte
// (tuser low), which also allows hashing an empty message.
module sha256_stream_hasher import sha_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_axis_tlast    // last_word
);

    logic fb_valid, fb_ready, qc_valid, qc_ready;
    t_blk fb_blk, qc_blk;
    logic [31:0] c_word;
    logic [2:0]  c_idx;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_has_byte(s_axis_tuser), .i_end(s_axis_tlast),
        .o_blk_valid(fb_valid), .i_blk_ready(fb_ready), .o_blk(fb_blk)
    );

    sha_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(fb_valid), .o_ready(fb_ready), .i_data(fb_blk),
        .o_valid(qc_valid), .i_ready(qc_ready), .o_data(qc_blk)
    );

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_blk_valid(qc_valid), .o_blk_ready(qc_ready), .i_blk(qc_blk),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(c_word), .o_index(c_idx), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, c_idx, c_word};

    // The last digest word is always word seven.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == 3'd7)
        else $error("last beat not word seven");

    // Word index advances by one after each accepted non-final word.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
        else $error("digest word index skipped");

    // The queue never reports both full and empty.
    a_fifo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fb_ready == 1'b0 && qc_valid == 1'b0))
        else $error("block queue state inconsistent");

endmodule
`default_nettype wire

// File: test/sha256_stream_hasher_tb.sv
// Testbench for the SHA-256 stream hasher: drives byte beats, predicts each digest
// with its own SHA-256 implementation and checks every digest word beat.
// Depends on sha_pkg and the sha256_stream_hasher RTL.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;
    import sha_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] has_byte
    logic        s_axis_tlast;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index, zero fill
    logic        m_axis_tlast;   // last_word

    sha256_stream_hasher u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    // Round constants, kept locally so the predictor is independent of the RTL.
    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam int MAX_CYCLES = 400000;

    // Predictor state.
    logic [31:0] pred_hash [8];
    logic [7:0]  pred_block [64];
    int          pred_fill;
    logic [63:0] pred_bits;

    t_digest_beat digest_q [$];
    int  send_idle_pct;
    int  recv_idle_pct;
    int  error_count;
    int  cycle_count;
    bit  done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void compress_pred();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = {pred_block[4*r], pred_block[4*r+1], pred_block[4*r+2], pred_block[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = w[r-16] + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3))
                 + w[r-7] + (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = pred_hash[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) pred_hash[i] += v[i];
    endfunction

    function automatic void restart_pred();
        for (int i = 0; i < 8; i++) pred_hash[i] = H_INIT[i];
        pred_fill = 0;
        pred_bits = '0;
    endfunction

    // Advances the predictor by one accepted beat and queues the digest on tlast.
    function automatic void predict_beat(input logic [7:0] b, input logic has, input logic eom);
        t_digest_beat d;
        if (has) begin
            pred_block[pred_fill] = b;
            pred_fill++;
            pred_bits += 64'd8;
            if (pred_fill == 64) begin
                compress_pred();
                pred_fill = 0;
            end
        end
        if (eom) begin
            pred_block[pred_fill] = 8'h80;
            for (int i = pred_fill + 1; i < 64; i++) pred_block[i] = 8'h00;
            if (pred_fill >= 56) begin
                compress_pred();
                for (int i = 0; i < 56; i++) pred_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) pred_block[63-i] = pred_bits[8*i +: 8];
            compress_pred();
            for (int i = 0; i < 8; i++) begin
                d.word  = pred_hash[i];
                d.index = i[2:0];
                d.last  = (i == 7);
                digest_q.push_back(d);
            end
            restart_pred();
        end
    endfunction

    // Sends one beat, with a random gap before it per the current idle rate.
    // Valid drops only while the sender idles, so back-to-back beats keep it high.
    task automatic send_byte(input logic [7:0] b, input logic has, input logic eom);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= has;
        s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_beat(b, has, eom);
    endtask

    task automatic send_message(input int len);
        logic empty_end;
        empty_end = 1'($urandom_range(1, 0));
        if (len == 0) empty_end = 1'b1;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19, 0) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
            send_byte(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
        end
        if (empty_end) send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, and a check of each digest word beat.
    always @(posedge i_clk) begin
        t_digest_beat got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.word  = m_axis_tdata[31:0];
                got.index = m_axis_tdata[34:32];
                got.last  = m_axis_tlast;
                if (digest_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) $display("Unexpected digest beat %h", got);
                end else begin
                    want = digest_q.pop_front();
                    if (got !== want || m_axis_tdata[39:35] !== 5'd0) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("Digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                                     want.word, want.index, want.last,
                                     got.word, got.index, got.last);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES && !done) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        // Empty message, one byte, extremes of the byte, an idle beat and abc.
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'haa, 1'b0, 1'b1);
        send_byte(8'h55, 1'b1, 1'b1);
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h62, 1'b1, 1'b0);
        send_byte(8'h63, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_block_boundaries();
        // Fill 55, 56, 63, 64 and 119 bytes: one or two final blocks.
        send_message(55);
        send_message(56);
        wait_drained();  // sender holds off until every digest has come
        send_message(63);
        send_message(64);
        send_message(119);
    endtask

    task automatic test_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(130, 0) : $urandom_range(12, 0);
            send_message(len);
            sent += len + 1;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        done          = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 53;
        for (int i = 0; i < 64; i++) pred_block[i] = '0;
        restart_pred();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_block_boundaries();
        test_random(20);
        send_idle_pct = 53;
        recv_idle_pct = 35;
        test_random(20);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(20);

        wait_drained();
        repeat (150) @(posedge i_clk);
        done = 1'b1;
        if (error_count == 0 && digest_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
